@@ rtl/xml_entity_stream_decoder_top_defines.svh @@
// Assertion macros for the entity decoder.
`ifndef XML_ENTITY_STREAM_DECODER_TOP_DEFINES_SVH
`define XML_ENTITY_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, quiet during reset
`define XESD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xesd: same-cycle check failed");
// Next-cycle implication, sampled on clk, quiet during reset
`define XESD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xesd: next-cycle check failed");
`else
`define XESD_ASSERT_IMPL(lbl, ante, cons)
`define XESD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/xesd_pkg.sv @@
package xesd_pkg;

  // Sizes
  localparam int ENTITY_MAX_BYTES = 13;
  localparam int POS_W            = $clog2(ENTITY_MAX_BYTES);
  localparam int BYTE_W           = 8;
  localparam int CODE_W           = 20;
  localparam int STATUS_W         = 2;
  localparam int DIG_W            = 3;
  localparam int NAME_N           = 18;
  localparam int NAME_SLOTS       = 8;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_CHAR   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FORBID = 2'd2;

  // Characters of interest
  localparam logic [BYTE_W-1:0] AMP_CHAR   = "&";
  localparam logic [BYTE_W-1:0] SEMI_CHAR  = ";";
  localparam logic [BYTE_W-1:0] HASH_CHAR  = "#";
  localparam logic [BYTE_W-1:0] QUOT_CHAR  = 8'h22;
  localparam logic [BYTE_W-1:0] APOS_CHAR  = 8'h27;
  localparam logic [BYTE_W-1:0] LT_CHAR    = "<";
  localparam logic [BYTE_W-1:0] GT_CHAR    = ">";
  localparam logic [BYTE_W-1:0] LOWX_CHAR  = "x";
  localparam logic [BYTE_W-1:0] UPX_CHAR   = "X";
  localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;

  // Token kinds passed from front to back
  typedef enum logic [1:0] {
    TK_CHAR,
    TK_FORBID,
    TK_BODY,
    TK_CLOSE
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t               kind;
    logic [POS_W-1:0]        pos;
    logic [BYTE_W-1:0]       data;
  } tok_t;

  typedef struct packed {
    logic can_push;
    logic can_pop;
  } fifo_stat_t;

  // Numeric entity scanner state
  typedef enum logic [2:0] {
    NM_START,
    NM_PREFIX,
    NM_DEC,
    NM_HEX,
    NM_BAD
  } num_mode_t;

  // Named entity table: text, last index (the ';'), code
  localparam logic [BYTE_W-1:0] NAME_TEXT [NAME_N][NAME_SLOTS] = '{
    '{"l", "t", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"g", "t", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"a", "m", "p", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"a", "p", "o", "s", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"a", "s", "l", "a", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"q", "u", "o", "t", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"n", "l", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"c", "r", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"b", "e", "l", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"f", "f", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"b", "s", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"s", "p", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"t", "a", "b", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"v", "t", "b", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"e", "s", "c", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"d", "e", "l", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"n", "u", "l", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
    '{"n", "b", "s", "p", ";", NUL_CHAR, NUL_CHAR, NUL_CHAR}
  };

  localparam logic [2:0] NAME_LAST [NAME_N] = '{
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4
  };

  localparam logic [7:0] NAME_CODE [NAME_N] = '{
    8'd60, 8'd62, 8'd38, 8'd39, 8'd92, 8'd34, 8'd10, 8'd13, 8'd7,
    8'd12, 8'd8,  8'd32, 8'd9,  8'd11, 8'd27, 8'd127, 8'd0, 8'd160
  };

  // Character classes
  function automatic logic is_dec_char(input logic [BYTE_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex_char(input logic [BYTE_W-1:0] c);
    return is_dec_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // Nibble value of a hex digit; letters have bit 6 set, low bits 1..6
  function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] c);
    logic [3:0] v;
    if (c[6]) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage

@@ rtl/xesd_in_if.sv @@
interface xesd_in_if;
  import xesd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/xesd_out_if.sv @@
interface xesd_out_if;
  import xesd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   char_code;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output char_code, output status, input ready);
  modport sink   (input valid, input char_code, input status, output ready);
endinterface

@@ rtl/xesd_front.sv @@
module xesd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                strict_mode,
  xesd_in_if.sink             in_ch,
  input  xesd_pkg::fifo_stat_t fstat,
  output logic                push,
  output xesd_pkg::tok_t      tok
);
  import xesd_pkg::*;

  logic             in_entity_r, in_entity_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             last_byte;
  logic             forbidden;

  // Input transfer whenever the queue has room
  assign in_ch.ready = fstat.can_push;
  assign accept      = in_ch.valid && in_ch.ready;

  assign last_byte = (in_ch.in_byte == SEMI_CHAR) ||
                     (count_r == POS_W'(ENTITY_MAX_BYTES - 1));
  assign forbidden = strict_mode &&
                     ((in_ch.in_byte == QUOT_CHAR) || (in_ch.in_byte == APOS_CHAR) ||
                      (in_ch.in_byte == LT_CHAR)   || (in_ch.in_byte == GT_CHAR));

  // Classify the byte; the opening ampersand produces no token
  always_comb begin
    tok.data      = in_ch.in_byte;
    tok.pos       = count_r;
    tok.kind      = TK_CHAR;
    push          = 1'b0;
    in_entity_nxt = in_entity_r;
    count_nxt     = count_r;
    if (in_entity_r) begin
      tok.kind = last_byte ? TK_CLOSE : TK_BODY;
      push     = accept;
      if (accept) begin
        if (last_byte) begin
          in_entity_nxt = 1'b0;
          count_nxt     = '0;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
    end else if (in_ch.in_byte == AMP_CHAR) begin
      if (accept) begin
        in_entity_nxt = 1'b1;
        count_nxt     = '0;
      end
    end else begin
      tok.kind = forbidden ? TK_FORBID : TK_CHAR;
      push     = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_entity_r <= 1'b0;
      count_r     <= '0;
    end else begin
      in_entity_r <= in_entity_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

@@ rtl/xesd_fifo.sv @@
module xesd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  xesd_pkg::tok_t       push_tok,
  input  logic                 pop,
  output xesd_pkg::tok_t       head_tok,
  output xesd_pkg::fifo_stat_t fstat
);
  import xesd_pkg::*;

  // Two-entry token queue
  tok_t       slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] level_r, level_nxt;

  assign fstat.can_push = (level_r != 2'd2);
  assign fstat.can_pop  = (level_r != 2'd0);
  assign head_tok       = slot_r[rptr_r];

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      level_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      level_r <= level_nxt;
    end
  end

endmodule

@@ rtl/xesd_back.sv @@
module xesd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xesd_pkg::tok_t       head_tok,
  input  xesd_pkg::fifo_stat_t fstat,
  output logic                 pop,
  xesd_out_if.source           out_ch
);
  import xesd_pkg::*;

  logic [BYTE_W-1:0]   b;
  logic                fresh;
  logic                entity_tok;

  // Entity scan state
  logic [NAME_N-1:0]   cand_r, cand_nxt, cand_base;
  num_mode_t           mode_r, mode_nxt, mode_base;
  logic [CODE_W-1:0]   val_r, val_nxt, val_base;
  logic [DIG_W-1:0]    ndig_r, ndig_nxt, ndig_base;
  logic [NAME_N-1:0]   name_hit;

  // Result
  logic                name_ok, num_ok;
  logic [CODE_W-1:0]   name_code;
  logic [CODE_W-1:0]   res_code;
  logic [STATUS_W-1:0] res_status;
  logic                res_valid;

  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   code_r;
  logic [STATUS_W-1:0] status_r;

  // Pop when the output register is free or being drained
  assign pop        = fstat.can_pop && (!out_valid_r || out_ch.ready);
  assign b          = head_tok.data;
  assign fresh      = (head_tok.pos == '0);
  assign entity_tok = (head_tok.kind == TK_BODY) || (head_tok.kind == TK_CLOSE);

  // First byte of an entity starts from a clean scan
  always_comb begin
    cand_base = fresh ? '1 : cand_r;
    mode_base = fresh ? NM_START : mode_r;
    val_base  = fresh ? '0 : val_r;
    ndig_base = fresh ? '0 : ndig_r;
  end

  // Named entity candidates narrowed one byte at a time
  always_comb begin
    for (int k = 0; k < NAME_N; k++) begin
      cand_nxt[k] = cand_base[k] &&
                    (head_tok.pos <= POS_W'(NAME_LAST[k])) &&
                    (NAME_TEXT[k][head_tok.pos[2:0]] == b);
      name_hit[k] = cand_nxt[k] && (head_tok.pos == POS_W'(NAME_LAST[k]));
    end
  end

  // Numeric scanner next state
  always_comb begin
    mode_nxt = NM_BAD;
    unique case (mode_base)
      NM_START:  mode_nxt = (b == HASH_CHAR) ? NM_PREFIX : NM_BAD;
      NM_PREFIX: begin
        if (is_dec_char(b)) begin
          mode_nxt = NM_DEC;
        end else if ((b == LOWX_CHAR) || (b == UPX_CHAR)) begin
          mode_nxt = NM_HEX;
        end else begin
          mode_nxt = NM_BAD;
        end
      end
      NM_DEC:    mode_nxt = is_dec_char(b) ? NM_DEC : NM_BAD;
      NM_HEX:    mode_nxt = is_hex_char(b) ? NM_HEX : NM_BAD;
      NM_BAD:    mode_nxt = NM_BAD;
      default:   mode_nxt = NM_BAD;
    endcase
  end

  // Digit accumulation; the count saturates past the longest legal string
  always_comb begin
    val_nxt  = val_base;
    ndig_nxt = ndig_base;
    if (mode_nxt == NM_DEC) begin
      val_nxt  = {val_base[CODE_W-4:0], 3'b000} + {val_base[CODE_W-2:0], 1'b0} +
                 CODE_W'(b[3:0]);
    end else if ((mode_nxt == NM_HEX) && (mode_base == NM_HEX)) begin
      val_nxt  = {val_base[CODE_W-5:0], hex_nibble(b)};
    end
    if (((mode_nxt == NM_DEC) || ((mode_nxt == NM_HEX) && (mode_base == NM_HEX))) &&
        (ndig_base != '1)) begin
      ndig_nxt = ndig_base + 1'b1;
    end
  end

  // Result of the token at the queue head
  always_comb begin
    name_code = '0;
    for (int k = 0; k < NAME_N; k++) begin
      if (name_hit[k]) begin
        name_code = name_code | CODE_W'(NAME_CODE[k]);
      end
    end
    name_ok = |name_hit;
    num_ok  = (b == SEMI_CHAR) &&
              (((mode_base == NM_DEC) && (ndig_base != DIG_W'(7))) ||
               ((mode_base == NM_HEX) && (ndig_base <= DIG_W'(5))));
    res_valid  = 1'b1;
    res_code   = CODE_W'(b);
    res_status = ST_CHAR;
    case (head_tok.kind) inside
      TK_CHAR:   res_status = ST_CHAR;
      TK_FORBID: res_status = ST_FORBID;
      TK_CLOSE: begin
        if (name_ok) begin
          res_code   = name_code;
          res_status = ST_CHAR;
        end else if (num_ok) begin
          res_code   = val_base;
          res_status = ST_CHAR;
        end else begin
          res_code   = '0;
          res_status = ST_BAD;
        end
      end
      default:   res_valid = 1'b0;
    endcase
  end

  // Output register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= NM_START;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop && entity_tok) begin
        mode_r <= mode_nxt;
      end
    end
  end

  // Scan datapath and result payload
  always_ff @(posedge clk) begin
    if (pop && entity_tok) begin
      cand_r <= cand_nxt;
      val_r  <= val_nxt;
      ndig_r <= ndig_nxt;
    end
    if (pop && res_valid) begin
      code_r   <= res_code;
      status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = code_r;
  assign out_ch.status    = status_r;

endmodule

@@ rtl/xml_entity_stream_decoder_top.sv @@
// A plain byte or the closing byte of an entity gives its result through the queue stage,
// then the output register. Throughput: one byte per cycle while the queue has room; the
// opening ampersand and inner entity bytes give none.
// The entity scan runs byte by byte, so no cycle depends on entity length.
// Reset (rst_n low at a clock edge, synchronous) empties the queue and output and clears
// strict_mode; there is no clearing pass.
module xml_entity_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  xesd_in_if.sink     in_ch,
  xesd_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import xesd_pkg::*;

`include "xml_entity_stream_decoder_top_defines.svh"

  logic       strict_r;
  logic       push, pop;
  tok_t       push_tok, head_tok;
  fifo_stat_t fstat;
  logic       out_forbid, out_bad, out_special;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else if (cfg_wr_en) begin
      strict_r <= cfg_wr_data;
    end
  end

  xesd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .strict_mode (strict_r),
    .in_ch       (in_ch),
    .fstat       (fstat),
    .push        (push),
    .tok         (push_tok)
  );

  xesd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .fstat    (fstat)
  );

  xesd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_tok (head_tok),
    .fstat    (fstat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // Result classes seen by the checks
  assign out_forbid  = out_ch.valid && (out_ch.status == ST_FORBID);
  assign out_bad     = out_ch.valid && (out_ch.status == ST_BAD);
  assign out_special = (out_ch.char_code == CODE_W'(QUOT_CHAR)) ||
                       (out_ch.char_code == CODE_W'(APOS_CHAR)) ||
                       (out_ch.char_code == CODE_W'(LT_CHAR))   ||
                       (out_ch.char_code == CODE_W'(GT_CHAR));

  // Checks
  `XESD_ASSERT_IMPL(a_forbid_needs_strict, out_forbid, strict_r)
  `XESD_ASSERT_IMPL(a_bad_code_zero, out_bad, out_ch.char_code == '0)
  `XESD_ASSERT_IMPL(a_forbid_byte, out_forbid, out_special)
  `XESD_ASSERT_NEXT(a_room_after_drain, out_ch.valid && out_ch.ready, fstat.can_push)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import xesd_pkg::*;

  localparam int SCAN_LEN   = ENTITY_MAX_BYTES + 2;
  localparam int NAME_COUNT = 18;
  localparam int DIR_ROWS   = 31;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PHASE_BYTES = 170;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] st;
  } char_result_t;

  // One directed row: a byte string, or a single raw byte when the string is empty
  typedef struct {
    string               text;
    logic [BYTE_W-1:0]   raw;
    logic                strict;
    logic                typed;
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] st;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  xesd_in_if  in_bus ();
  xesd_out_if out_bus ();

  xml_entity_stream_decoder_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Decoder model state
  logic [BYTE_W-1:0] ent_buf [ENTITY_MAX_BYTES];
  int unsigned       ent_len;
  bit                collecting;
  bit                strict_q;

  char_result_t pending_chars [$];
  int           errors;
  int           bytes_sent;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_req;
  int           hold_left;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // raw extremes and specials, strict off
    '{"",               8'h00, 1'b0, 1'b1, 20'h00000, ST_CHAR},
    '{"",               8'hFF, 1'b0, 1'b1, 20'h000FF, ST_CHAR},
    '{"\"",             8'h00, 1'b0, 1'b1, 20'h00022, ST_CHAR},
    '{"'<>",            8'h00, 1'b0, 1'b0, 20'h00000, ST_CHAR},
    // named entities
    '{"&lt;",           8'h00, 1'b0, 1'b1, 20'd60,    ST_CHAR},
    '{"&nbsp;",         8'h00, 1'b0, 1'b1, 20'd160,   ST_CHAR},
    '{"&asla;",         8'h00, 1'b0, 1'b1, 20'd92,    ST_CHAR},
    '{"&vtb;",          8'h00, 1'b0, 1'b1, 20'd11,    ST_CHAR},
    '{"&esc;",          8'h00, 1'b0, 1'b1, 20'd27,    ST_CHAR},
    '{"&del;",          8'h00, 1'b0, 1'b1, 20'd127,   ST_CHAR},
    '{"&nul;",          8'h00, 1'b0, 1'b1, 20'd0,     ST_CHAR},
    // numeric entities and digit limits
    '{"&#0;",           8'h00, 1'b0, 1'b1, 20'd0,     ST_CHAR},
    '{"&#999999;",      8'h00, 1'b0, 1'b1, 20'd999999, ST_CHAR},
    '{"&#1234567;",     8'h00, 1'b0, 1'b1, 20'd0,     ST_BAD},
    '{"&#x;",           8'h00, 1'b0, 1'b1, 20'd0,     ST_CHAR},
    '{"&#XfFfFf;",      8'h00, 1'b0, 1'b1, 20'hFFFFF, ST_CHAR},
    '{"&#x123456;",     8'h00, 1'b0, 1'b1, 20'd0,     ST_BAD},
    '{"&#x0000a;",      8'h00, 1'b0, 1'b0, 20'd0,     ST_CHAR},
    // full store with no semicolon
    '{"&abcdefghijklm", 8'h00, 1'b0, 1'b1, 20'd0,     ST_BAD},
    // zero byte inside an entity
    '{"&#1",            8'h00, 1'b0, 1'b0, 20'd0,     ST_CHAR},
    '{"",               8'h00, 1'b0, 1'b0, 20'd0,     ST_CHAR},
    '{";",              8'h00, 1'b0, 1'b1, 20'd0,     ST_BAD},
    '{"&AMP;",          8'h00, 1'b0, 1'b0, 20'd0,     ST_CHAR},
    '{"&;",             8'h00, 1'b0, 1'b0, 20'd0,     ST_CHAR},
    // strict mode: raw specials flagged, entity bytes never flagged
    '{"\"",             8'h00, 1'b1, 1'b1, 20'h00022, ST_FORBID},
    '{"'",              8'h00, 1'b1, 1'b1, 20'h00027, ST_FORBID},
    '{"<",              8'h00, 1'b1, 1'b1, 20'h0003C, ST_FORBID},
    '{">",              8'h00, 1'b1, 1'b1, 20'h0003E, ST_FORBID},
    '{"&quot;",         8'h00, 1'b1, 1'b1, 20'd34,    ST_CHAR},
    '{"&<>\"';",        8'h00, 1'b1, 1'b1, 20'd0,     ST_BAD},
    '{"Az",             8'h00, 1'b1, 1'b0, 20'd0,     ST_CHAR}
  };

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic string ent_text(input int k);
    case (k)
      0:       return "lt;";
      1:       return "gt;";
      2:       return "amp;";
      3:       return "apos;";
      4:       return "asla;";
      5:       return "quot;";
      6:       return "nl;";
      7:       return "cr;";
      8:       return "bel;";
      9:       return "ff;";
      10:      return "bs;";
      11:      return "sp;";
      12:      return "tab;";
      13:      return "vtb;";
      14:      return "esc;";
      15:      return "del;";
      16:      return "nul;";
      default: return "nbsp;";
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] ent_code(input int k);
    case (k)
      0:       return 20'd60;
      1:       return 20'd62;
      2:       return 20'd38;
      3:       return 20'd39;
      4:       return 20'd92;
      5:       return 20'd34;
      6:       return 20'd10;
      7:       return 20'd13;
      8:       return 20'd7;
      9:       return 20'd12;
      10:      return 20'd8;
      11:      return 20'd32;
      12:      return 20'd9;
      13:      return 20'd11;
      14:      return 20'd27;
      15:      return 20'd127;
      16:      return 20'd0;
      default: return 20'd160;
    endcase
  endfunction

  function automatic bit is_digit(input logic [BYTE_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // -1 when c is not a hex digit
  function automatic int hex_digit(input logic [BYTE_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Decode the gathered entity text; 0 means bad entity
  function automatic bit resolve_entity(output logic [CODE_W-1:0] val);
    logic [BYTE_W-1:0] s [SCAN_LEN];
    string             nm;
    bit                hit;
    int                i;
    int                k;
    logic [31:0]       acc;
    val = '0;
    acc = '0;
    for (i = 0; i < SCAN_LEN; i++) s[i] = NUL_CHAR;
    s[0] = AMP_CHAR;
    for (i = 0; i < int'(ent_len) && i < ENTITY_MAX_BYTES; i++) s[i+1] = ent_buf[i];
    // named entities: the name must match up to and including its semicolon
    for (k = 0; k < NAME_COUNT; k++) begin
      nm = ent_text(k);
      hit = 1'b1;
      for (i = 0; i < nm.len(); i++) begin
        if (s[i+1] != nm[i]) hit = 1'b0;
      end
      if (hit) begin
        val = ent_code(k);
        return 1'b1;
      end
    end
    if (s[1] != HASH_CHAR) return 1'b0;
    // decimal: 1 to 6 digits then a semicolon
    if (is_digit(s[2])) begin
      for (i = 2; i < 9 && is_digit(s[i]); i++) acc = acc * 10 + 32'(s[i] - "0");
      if (i >= 9 || s[i] != SEMI_CHAR) return 1'b0;
      val = acc[CODE_W-1:0];
      return 1'b1;
    end
    // hex: 0 to 5 digits then a semicolon
    if (s[2] == LOWX_CHAR || s[2] == UPX_CHAR) begin
      for (i = 3; i < 9 && hex_digit(s[i]) >= 0; i++) acc = (acc << 4) | 32'(hex_digit(s[i]));
      if (i >= 9 || s[i] != SEMI_CHAR) return 1'b0;
      val = acc[CODE_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the model by one byte; 1 when the byte yields a result
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b,
                                     output logic [CODE_W-1:0] code,
                                     output logic [STATUS_W-1:0] st);
    bit                ok;
    logic [CODE_W-1:0] val;
    code = '0;
    st   = ST_CHAR;
    if (!collecting) begin
      if (b == AMP_CHAR) begin
        collecting = 1'b1;
        ent_len    = 0;
        return 1'b0;
      end
      code = CODE_W'(b);
      if (strict_q && (b == QUOT_CHAR || b == APOS_CHAR || b == LT_CHAR || b == GT_CHAR)) begin
        st = ST_FORBID;
      end
      return 1'b1;
    end
    if (ent_len < ENTITY_MAX_BYTES) begin
      ent_buf[ent_len] = b;
      ent_len++;
    end
    if (b != SEMI_CHAR && ent_len < ENTITY_MAX_BYTES) return 1'b0;
    collecting = 1'b0;
    ok = resolve_entity(val);
    ent_len = 0;
    if (ok) code = val;
    else st = ST_BAD;
    return 1'b1;
  endfunction

  // Offer one byte, wait for its transfer, then queue what it should produce
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                           input logic [CODE_W-1:0] t_code = '0,
                           input logic [STATUS_W-1:0] t_st = ST_CHAR);
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] st;
    char_result_t        res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (decode_byte(b, code, st)) begin
      res.code = typed ? t_code : code;
      res.st   = typed ? t_st : st;
      pending_chars.push_back(res);
    end
    bytes_sent++;
  endtask

  // Stop sending and wait for every queued result, then let the pipe settle
  task automatic drain_results();
    int waited;
    in_bus.valid <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $display("%0t: missing result, expected code %0h status %0d, got nothing (%0d left)",
               $time, pending_chars[0].code, pending_chars[0].st, pending_chars.size());
      errors++;
      pending_chars.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_strict(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    strict_q    = v;
  endtask

  // One random chunk of text: plain bytes, well-formed or corrupted entities, or broken ones
  task automatic send_random_unit();
    int                kind;
    int                n;
    int                i;
    int                pos;
    int                v;
    string             nm;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // plain bytes, specials often
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       b = QUOT_CHAR;
            1:       b = APOS_CHAR;
            2:       b = LT_CHAR;
            default: b = GT_CHAR;
          endcase
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_byte(b);
      end
    end else if (kind < 50) begin
      // named entity, sometimes with one byte corrupted
      nm  = ent_text($urandom_range(0, NAME_COUNT - 1));
      pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nm.len() - 1) : -1;
      send_byte(AMP_CHAR);
      for (i = 0; i < nm.len(); i++) begin
        send_byte((i == pos) ? 8'($urandom_range(0, 255)) : nm[i]);
      end
    end else if (kind < 65) begin
      // decimal, occasionally one digit too many
      n = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(1, 6);
      send_byte(AMP_CHAR);
      send_byte(HASH_CHAR);
      for (i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)));
      send_byte(SEMI_CHAR);
    end else if (kind < 80) begin
      // hex with mixed case, occasionally one digit too many
      n = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(0, 5);
      send_byte(AMP_CHAR);
      send_byte(HASH_CHAR);
      send_byte($urandom_range(0, 1) ? LOWX_CHAR : UPX_CHAR);
      for (i = 0; i < n; i++) begin
        v = $urandom_range(0, 15);
        if (v < 10) b = 8'("0" + v);
        else if ($urandom_range(0, 1) == 1) b = 8'("a" + v - 10);
        else b = 8'("A" + v - 10);
        send_byte(b);
      end
      send_byte(SEMI_CHAR);
    end else if (kind < 90) begin
      // broken entity: random body of random length
      n = $urandom_range(1, 14);
      send_byte(AMP_CHAR);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // runs into a full store without a semicolon
      send_byte(AMP_CHAR);
      for (i = 0; i < ENTITY_MAX_BYTES; i++) begin
        b = 8'($urandom_range(0, 255));
        send_byte((b == SEMI_CHAR) ? 8'("A") : b);
      end
    end
  endtask

  // Result side: ready with random stalls, long hold-off on request, check each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, got code %0h status %0d",
                   $time, out_bus.char_code, out_bus.status);
          errors++;
        end else begin
          if (out_bus.char_code !== pending_chars[0].code ||
              out_bus.status !== pending_chars[0].st) begin
            $display("%0t: mismatch, expected code %0h status %0d, got code %0h status %0d",
                     $time, pending_chars[0].code, pending_chars[0].st,
                     out_bus.char_code, out_bus.status);
            errors++;
          end
          void'(pending_chars.pop_front());
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int r;
    int i;
    int phase;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.in_byte <= '0;
    strict_q    = 1'b0;
    collecting  = 1'b0;
    ent_len     = 0;
    errors      = 0;
    bytes_sent  = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 29;
    rx_idle_pct = 53;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      if (r == 0 || dir_rows[r].strict != strict_q) begin
        drain_results();
        write_strict(dir_rows[r].strict);
      end
      if (dir_rows[r].text.len() == 0) begin
        send_byte(dir_rows[r].raw, dir_rows[r].typed, dir_rows[r].code, dir_rows[r].st);
      end else begin
        for (i = 0; i < dir_rows[r].text.len(); i++) begin
          send_byte(dir_rows[r].text[i], dir_rows[r].typed && (i == dir_rows[r].text.len() - 1),
                    dir_rows[r].code, dir_rows[r].st);
        end
      end
    end

    // random phases: idle mix changes every two phases, strict alternates
    for (phase = 0; phase < 6; phase++) begin
      drain_results();
      write_strict(1'(phase % 2));
      case (phase / 2)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 53;
        end
        1: begin
          tx_idle_pct = 53;
          rx_idle_pct = 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // back up the block while bytes keep coming
      if (phase == 4) hold_req = 1'b1;
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_random_unit();
      // close an open entity so the block is idle for the next write
      if (collecting) send_byte(SEMI_CHAR);
    end
    drain_results();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
